FILE: rtl/lmsc_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller package
// Shared sizes, command codes and the command record passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package lmsc_pkg;

	// Geometry of the two cell stores.
	localparam int MAX_ROWS    = 24;
	localparam int MAX_COLS    = 16;
	localparam int LEVEL_BITS  = 12;
	localparam int MAX_RESULTS = 24;
	localparam int CELLS       = MAX_ROWS * MAX_COLS;
	localparam int CELL_AW     = $clog2(CELLS);

	// Field widths fixed by the port list.
	localparam int FUNC_W  = 3;
	localparam int RIDX_W  = 5;
	localparam int CIDX_W  = 4;
	localparam int VAL_W   = 16;
	localparam int CHAN_W  = 5;
	localparam int LVL_W   = 12;
	localparam int SEL_W   = 16;
	localparam int REG_W   = 5;
	localparam int REGIX_W = 2;

	// Internal counter widths.
	localparam int CNT_MAX     = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int CNT_W       = $clog2(CNT_MAX + 1);
	localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int EFF_ROW_LIM = (MAX_ROWS < MAX_RESULTS) ? MAX_ROWS : MAX_RESULTS;

	// Mask applied to a drive cell to form the level.
	localparam logic [VAL_W-1:0] LVL_MASK = VAL_W'(((1 << LEVEL_BITS) - 1) & 'hFFF);

	// Reset values and indexes of the configuration registers.
	localparam logic [REG_W-1:0]   ROW_COUNT_RST = REG_W'(24);
	localparam logic [REG_W-1:0]   COL_COUNT_RST = REG_W'(8);
	localparam logic [REGIX_W-1:0] REG_ROW_COUNT = REGIX_W'(0);
	localparam logic [REGIX_W-1:0] REG_COL_COUNT = REGIX_W'(1);

	// Command codes on the func port.
	typedef enum logic [FUNC_W-1:0] {
		FN_SET_CELL = 3'd0,
		FN_SET_ROW  = 3'd1,
		FN_SET_COL  = 3'd2,
		FN_SET_ALL  = 3'd3,
		FN_SWAP     = 3'd4,
		FN_READ     = 3'd5,
		FN_SCAN     = 3'd6
	} func_t;

	// Work kinds carried out by the back end.
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_COPY  = 2'd1,
		OP_READ  = 2'd2,
		OP_SCAN  = 2'd3
	} op_t;

	// One classified command waiting in the queue.
	typedef struct packed {
		op_t                op;
		logic [CELL_AW-1:0] addr;
		logic [CNT_W-1:0]   inner;
		logic [CNT_W-1:0]   outer;
		logic               stride_row;
		logic [VAL_W-1:0]   value;
		logic [COL_W-1:0]   col;
		logic               read_ok;
	} cmd_t;

	// Status reported by the back end to the front end.
	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

FILE: rtl/led_matrix_scan_controller_core.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller core
// Double-buffered LED matrix column scanner with a command front end,
// a two-entry command queue and a store-owning back end.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; busy rises only
// while the two-entry queue is full or while the post-reset clearing pass
// runs, zeroing both stores one cell a cycle. Row and column counts below
// are the register values clamped to 1..24 and 1..16. The back end takes a
// command from the queue while idle and then writes or reads one cell,
// fills a row, a column or the whole frame (row count x column count
// cells) one cell a cycle, copies all 384 frame cells to the drive store
// one cell a cycle through the single frame read port for a swap, or runs
// a scan tick, which emits one result beat per row channel on consecutive
// cycles. The store read of each beat is registered and the beat is then
// formed in the result register, each valid for exactly one cycle on strobe;
// the receiver must take every beat as it comes. Configuration writes
// are always ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module led_matrix_scan_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [lmsc_pkg::FUNC_W-1:0]   func,
	input  logic [lmsc_pkg::RIDX_W-1:0]   row_index,
	input  logic [lmsc_pkg::CIDX_W-1:0]   col_index,
	input  logic [lmsc_pkg::VAL_W-1:0]    cell_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lmsc_pkg::REGIX_W-1:0]  cfg_index,
	input  logic [lmsc_pkg::REG_W-1:0]    cfg_data,
	output logic                          strobe,
	output logic [lmsc_pkg::CHAN_W-1:0]   channel,
	output logic [lmsc_pkg::LVL_W-1:0]    level,
	output logic [lmsc_pkg::SEL_W-1:0]    column_select,
	output logic [lmsc_pkg::VAL_W-1:0]    read_value,
	output logic                          last
);

	logic                  push;
	lmsc_pkg::cmd_t        push_data;
	logic                  pop;
	lmsc_pkg::cmd_t        pop_data;
	logic                  q_full;
	logic                  q_empty;
	lmsc_pkg::back_stat_t  stat;

	// Command acceptance and classification.
	lmsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.row_index  (row_index),
		.col_index  (col_index),
		.cell_value (cell_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.stat       (stat),
		.push       (push),
		.push_data  (push_data)
	);

	// Work records waiting for the back end.
	lmsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Store access and result generation.
	lmsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (pop_data),
		.q_pop         (pop),
		.stat          (stat),
		.strobe        (strobe),
		.channel       (channel),
		.level         (level),
		.column_select (column_select),
		.read_value    (read_value),
		.last          (last)
	);

endmodule

FILE: rtl/lmsc_front.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller front end
// Holds the configuration registers and the scan column, accepts commands,
// checks their indexes and turns them into work records for the queue.
// ----------------------------------------------------------------------------
module lmsc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [lmsc_pkg::FUNC_W-1:0]   func,
	input  logic [lmsc_pkg::RIDX_W-1:0]   row_index,
	input  logic [lmsc_pkg::CIDX_W-1:0]   col_index,
	input  logic [lmsc_pkg::VAL_W-1:0]    cell_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lmsc_pkg::REGIX_W-1:0]  cfg_index,
	input  logic [lmsc_pkg::REG_W-1:0]    cfg_data,
	input  logic                          q_full,
	input  lmsc_pkg::back_stat_t          stat,
	output logic                          push,
	output lmsc_pkg::cmd_t                push_data
);

	logic [lmsc_pkg::REG_W-1:0]   row_count_q;
	logic [lmsc_pkg::REG_W-1:0]   col_count_q;
	logic [lmsc_pkg::COL_W-1:0]   scol_q;
	logic [lmsc_pkg::CNT_W-1:0]   nr;
	logic [lmsc_pkg::CNT_W-1:0]   nc;
	logic                         rok;
	logic                         cok;
	logic                         accept;
	logic [lmsc_pkg::COL_W-1:0]   cur_col;
	logic [lmsc_pkg::COL_W-1:0]   nxt_col;
	logic [lmsc_pkg::CELL_AW-1:0] col_base;
	logic [lmsc_pkg::CELL_AW-1:0] cur_base;
	lmsc_pkg::cmd_t               cmd;
	logic                         keep;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	assign busy      = q_full | stat.clearing;
	assign accept    = start & ~busy;

	// Effective counts, clamped to their legal ranges.
	always_comb begin
		if (row_count_q == '0) begin
			nr = lmsc_pkg::CNT_W'(1);
		end else if (32'(row_count_q) > lmsc_pkg::EFF_ROW_LIM) begin
			nr = lmsc_pkg::CNT_W'(lmsc_pkg::EFF_ROW_LIM);
		end else begin
			nr = lmsc_pkg::CNT_W'(row_count_q);
		end
		if (col_count_q == '0) begin
			nc = lmsc_pkg::CNT_W'(1);
		end else if (32'(col_count_q) > lmsc_pkg::MAX_COLS) begin
			nc = lmsc_pkg::CNT_W'(lmsc_pkg::MAX_COLS);
		end else begin
			nc = lmsc_pkg::CNT_W'(col_count_q);
		end
	end

	assign rok = 32'(row_index) < 32'(nr);
	assign cok = 32'(col_index) < 32'(nc);

	// Column taken by a scan tick and the one after it.
	assign cur_col = (32'(scol_q) < 32'(nc)) ? scol_q : '0;
	assign nxt_col = ((32'(cur_col) + 1) >= 32'(nc)) ? '0
		: lmsc_pkg::COL_W'(32'(cur_col) + 1);

	// Base addresses of the addressed column and the scanned column.
	assign col_base = lmsc_pkg::CELL_AW'(col_index) *
		lmsc_pkg::CELL_AW'(lmsc_pkg::MAX_ROWS);
	assign cur_base = lmsc_pkg::CELL_AW'(cur_col) *
		lmsc_pkg::CELL_AW'(lmsc_pkg::MAX_ROWS);

	// Classify the command into one work record.
	always_comb begin
		cmd            = '0;
		cmd.value      = cell_value;
		cmd.inner      = lmsc_pkg::CNT_W'(1);
		cmd.outer      = lmsc_pkg::CNT_W'(1);
		cmd.op         = lmsc_pkg::OP_WRITE;
		keep           = 1'b0;
		unique case (lmsc_pkg::func_t'(func))
			lmsc_pkg::FN_SET_CELL: begin
				cmd.addr = col_base + lmsc_pkg::CELL_AW'(row_index);
				keep     = rok & cok;
			end
			lmsc_pkg::FN_SET_ROW: begin
				cmd.addr       = lmsc_pkg::CELL_AW'(row_index);
				cmd.inner      = nc;
				cmd.stride_row = 1'b1;
				keep           = rok;
			end
			lmsc_pkg::FN_SET_COL: begin
				cmd.addr  = col_base;
				cmd.inner = nr;
				keep      = cok;
			end
			lmsc_pkg::FN_SET_ALL: begin
				cmd.inner = nr;
				cmd.outer = nc;
				keep      = 1'b1;
			end
			lmsc_pkg::FN_SWAP: begin
				cmd.op = lmsc_pkg::OP_COPY;
				keep   = 1'b1;
			end
			lmsc_pkg::FN_READ: begin
				cmd.op      = lmsc_pkg::OP_READ;
				cmd.addr    = col_base + lmsc_pkg::CELL_AW'(row_index);
				cmd.read_ok = rok & cok;
				keep        = 1'b1;
			end
			lmsc_pkg::FN_SCAN: begin
				cmd.op    = lmsc_pkg::OP_SCAN;
				cmd.addr  = cur_base + lmsc_pkg::CELL_AW'(nr) - lmsc_pkg::CELL_AW'(1);
				cmd.inner = nr;
				cmd.col   = cur_col;
				keep      = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push      = accept & keep;
	assign push_data = cmd;

	// Configuration registers and scan column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= lmsc_pkg::ROW_COUNT_RST;
			col_count_q <= lmsc_pkg::COL_COUNT_RST;
			scol_q      <= '0;
		end else begin
			if (cfg_valid && cfg_index == lmsc_pkg::REG_ROW_COUNT) begin
				row_count_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == lmsc_pkg::REG_COL_COUNT) begin
				col_count_q <= cfg_data;
			end
			if (accept && lmsc_pkg::func_t'(func) == lmsc_pkg::FN_SCAN) begin
				scol_q <= nxt_col;
			end
		end
	end

endmodule

FILE: rtl/lmsc_queue.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller command queue
// Two-entry queue of work records between the front and back ends.
// ----------------------------------------------------------------------------
module lmsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lmsc_pkg::cmd_t push_data,
	input  logic           pop,
	output lmsc_pkg::cmd_t pop_data,
	output logic           full,
	output logic           empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	lmsc_pkg::cmd_t           mem_q [DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;

	assign full     = (32'(count_q) == DEPTH);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The front end must never push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue overflow");

	// Nothing is popped from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");

endmodule

FILE: rtl/lmsc_back.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller back end
// Owns the frame and drive stores and works off queued records: cell
// writes and fills, the frame-to-drive copy, cell reads and column scans.
// ----------------------------------------------------------------------------
module lmsc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  lmsc_pkg::cmd_t               q_data,
	output logic                         q_pop,
	output lmsc_pkg::back_stat_t         stat,
	output logic                         strobe,
	output logic [lmsc_pkg::CHAN_W-1:0]  channel,
	output logic [lmsc_pkg::LVL_W-1:0]   level,
	output logic [lmsc_pkg::SEL_W-1:0]   column_select,
	output logic [lmsc_pkg::VAL_W-1:0]   read_value,
	output logic                         last
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_COPY,
		ST_READ,
		ST_SCAN
	} state_t;

	localparam logic [lmsc_pkg::CELL_AW-1:0] LAST_ADDR =
		lmsc_pkg::CELL_AW'(lmsc_pkg::CELLS - 1);
	localparam logic [lmsc_pkg::CELL_AW-1:0] ROW_STEP =
		lmsc_pkg::CELL_AW'(lmsc_pkg::MAX_ROWS);

	state_t                        state_q;
	logic [lmsc_pkg::CELL_AW-1:0]  addr_q;
	logic [lmsc_pkg::CELL_AW-1:0]  base_q;
	logic [lmsc_pkg::CNT_W-1:0]    inner_q;
	logic [lmsc_pkg::CNT_W-1:0]    inner_init_q;
	logic [lmsc_pkg::CNT_W-1:0]    outer_q;
	logic                          stride_row_q;
	logic [lmsc_pkg::VAL_W-1:0]    value_q;
	logic [lmsc_pkg::COL_W-1:0]    col_q;
	logic [lmsc_pkg::CNT_W-1:0]    chan_q;
	logic                          read_ok_q;

	logic                          scan_s1;
	logic                          read_s1;
	logic                          copy_s1;
	logic                          read_ok_s1;
	logic                          last_s1;
	logic [lmsc_pkg::CNT_W-1:0]    chan_s1;
	logic [lmsc_pkg::COL_W-1:0]    col_s1;
	logic [lmsc_pkg::CELL_AW-1:0]  addr_s1;

	logic                          strobe_q;
	logic [lmsc_pkg::CHAN_W-1:0]   channel_q;
	logic [lmsc_pkg::LVL_W-1:0]    level_q;
	logic [lmsc_pkg::SEL_W-1:0]    column_select_q;
	logic [lmsc_pkg::VAL_W-1:0]    read_value_q;
	logic                          last_q;

	logic [lmsc_pkg::VAL_W-1:0]    frame_mem [lmsc_pkg::CELLS];
	logic [lmsc_pkg::VAL_W-1:0]    drive_mem [lmsc_pkg::CELLS];
	logic [lmsc_pkg::VAL_W-1:0]    frame_rdata_q;
	logic [lmsc_pkg::VAL_W-1:0]    drive_rdata_q;

	logic                          frame_we;
	logic [lmsc_pkg::VAL_W-1:0]    frame_wd;
	logic                          drive_we;
	logic [lmsc_pkg::CELL_AW-1:0]  drive_wa;
	logic [lmsc_pkg::VAL_W-1:0]    drive_wd;
	logic [lmsc_pkg::CELL_AW-1:0]  next_base;

	assign q_pop         = (state_q == ST_IDLE) && !q_empty;
	assign stat.clearing = (state_q == ST_CLEAR);

	// Memory write controls: the clearing pass zeroes both stores.
	assign frame_we  = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign frame_wd  = (state_q == ST_CLEAR) ? '0 : value_q;
	assign drive_we  = (state_q == ST_CLEAR) || copy_s1;
	assign drive_wa  = copy_s1 ? addr_s1 : addr_q;
	assign drive_wd  = copy_s1 ? frame_rdata_q : '0;
	assign next_base = base_q + ROW_STEP;

	// Frame store with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[addr_q] <= frame_wd;
		end
		frame_rdata_q <= frame_mem[addr_q];
	end

	// Drive store with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (drive_we) begin
			drive_mem[drive_wa] <= drive_wd;
		end
		drive_rdata_q <= drive_mem[addr_q];
	end

	// Sequencer, read pipeline and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			addr_q          <= '0;
			base_q          <= '0;
			inner_q         <= '0;
			inner_init_q    <= '0;
			outer_q         <= '0;
			stride_row_q    <= 1'b0;
			value_q         <= '0;
			col_q           <= '0;
			chan_q          <= '0;
			read_ok_q       <= 1'b0;
			scan_s1         <= 1'b0;
			read_s1         <= 1'b0;
			copy_s1         <= 1'b0;
			read_ok_s1      <= 1'b0;
			last_s1         <= 1'b0;
			chan_s1         <= '0;
			col_s1          <= '0;
			addr_s1         <= '0;
			strobe_q        <= 1'b0;
			channel_q       <= '0;
			level_q         <= '0;
			column_select_q <= '0;
			read_value_q    <= '0;
			last_q          <= 1'b0;
		end else begin
			scan_s1  <= 1'b0;
			read_s1  <= 1'b0;
			copy_s1  <= 1'b0;
			addr_s1  <= addr_q;
			strobe_q <= scan_s1 | read_s1;

			// Result beat formed from the registered read data.
			if (scan_s1) begin
				channel_q       <= lmsc_pkg::CHAN_W'(chan_s1);
				level_q         <= lmsc_pkg::LVL_W'(drive_rdata_q & lmsc_pkg::LVL_MASK);
				column_select_q <= lmsc_pkg::SEL_W'(1) << col_s1;
				read_value_q    <= '0;
				last_q          <= last_s1;
			end else if (read_s1) begin
				channel_q       <= '0;
				level_q         <= '0;
				column_select_q <= '0;
				read_value_q    <= read_ok_s1 ? frame_rdata_q : '0;
				last_q          <= 1'b1;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						addr_q       <= q_data.addr;
						base_q       <= q_data.addr;
						inner_q      <= q_data.inner;
						inner_init_q <= q_data.inner;
						outer_q      <= q_data.outer;
						stride_row_q <= q_data.stride_row;
						value_q      <= q_data.value;
						col_q        <= q_data.col;
						chan_q       <= q_data.inner - 1'b1;
						read_ok_q    <= q_data.read_ok;
						unique case (q_data.op)
							lmsc_pkg::OP_WRITE: state_q <= ST_WRITE;
							lmsc_pkg::OP_COPY:  state_q <= ST_COPY;
							lmsc_pkg::OP_READ:  state_q <= ST_READ;
							lmsc_pkg::OP_SCAN:  state_q <= ST_SCAN;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WRITE: begin
					// Walk the inner run, then step to the next column.
					if (inner_q == lmsc_pkg::CNT_W'(1)) begin
						if (outer_q == lmsc_pkg::CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							base_q  <= next_base;
							addr_q  <= next_base;
							inner_q <= inner_init_q;
							outer_q <= outer_q - 1'b1;
						end
					end else begin
						addr_q  <= stride_row_q ? addr_q + ROW_STEP : addr_q + 1'b1;
						inner_q <= inner_q - 1'b1;
					end
				end
				ST_COPY: begin
					copy_s1 <= 1'b1;
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_READ: begin
					read_s1    <= 1'b1;
					read_ok_s1 <= read_ok_q;
					state_q    <= ST_IDLE;
				end
				ST_SCAN: begin
					// Highest channel first, one channel a cycle.
					scan_s1 <= 1'b1;
					chan_s1 <= chan_q;
					col_s1  <= col_q;
					last_s1 <= (chan_q == '0);
					if (inner_q == lmsc_pkg::CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q  <= addr_q - 1'b1;
						chan_q  <= chan_q - 1'b1;
						inner_q <= inner_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe        = strobe_q;
	assign channel       = channel_q;
	assign level         = level_q;
	assign column_select = column_select_q;
	assign read_value    = read_value_q;
	assign last          = last_q;

	// Only one kind of read is in flight in the pipeline at a time.
	a_one_read_kind: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({scan_s1, read_s1, copy_s1}))
		else $error("overlapping read kinds");

	// No result beat leaves during the clearing pass.
	a_quiet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !strobe_q)
		else $error("result during clearing pass");

	// The closing beat of a scan belongs to channel zero.
	a_scan_last: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_s1 && last_s1) |-> (chan_s1 == '0))
		else $error("scan ended on nonzero channel");

	// A copy beat never turns into a result beat.
	a_copy_silent: assert property (@(posedge clk) disable iff (!arst_n)
		copy_s1 |=> !strobe_q)
		else $error("copy produced a result");

endmodule
